FILE: sv/bounded_composition_counter_defines.svh
// ----------------------------------------------------------------------------
// Bounded composition counter: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_COMPOSITION_COUNTER_DEFINES_SVH
`define BOUNDED_COMPOSITION_COUNTER_DEFINES_SVH

// The expression holds at every clock edge.
`define BCC_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds at the clock edge after the antecedent.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Bounded composition counter package
// Field widths, microcode step numbers, control word layout and the program.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

	localparam int TARGET_W      = 14;
	localparam int COUNT_W       = 52;
	localparam int LIMIT_W       = 15;
	localparam int NUM_PARTS     = 5;
	localparam int PART_W        = $clog2(NUM_PARTS);
	localparam int CFG_IDX_W     = 3;
	localparam int MAX_TOTAL_DEF = 16383;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_SETUP  = 3'd1;
	localparam step_t STEP_INIT   = 3'd2;
	localparam step_t STEP_SWEEP  = 3'd3;
	localparam step_t STEP_NEXT   = 3'd4;
	localparam step_t STEP_RESULT = 3'd5;
	localparam step_t STEP_LOAD   = 3'd6;
	localparam step_t STEP_RETURN = 3'd7;

	typedef enum logic [2:0] {
		COND_NEVER      = 3'd0,
		COND_ALWAYS     = 3'd1,
		COND_NO_INPUT   = 3'd2,
		COND_ZERO       = 3'd3,
		COND_SWEEP_BUSY = 3'd4,
		COND_MORE_PARTS = 3'd5,
		COND_OUT_FULL   = 3'd6
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  setup;
		logic  init_pass;
		logic  sweep;
		logic  next_part;
		logic  rd_result;
		logic  load_out;
		cond_t cond;
		step_t jump;
	} ctrl_word_t;

	localparam ctrl_word_t CTRL_NOP = '{
		in_ready: 1'b0, setup: 1'b0, init_pass: 1'b0, sweep: 1'b0,
		next_part: 1'b0, rd_result: 1'b0, load_out: 1'b0,
		cond: COND_NEVER, jump: STEP_IDLE
	};

	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t w;
		w = CTRL_NOP;
		case (step)
			STEP_IDLE: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NO_INPUT;
				w.jump     = STEP_IDLE;
			end
			STEP_SETUP: begin
				w.setup = 1'b1;
				w.cond  = COND_ZERO;
				w.jump  = STEP_LOAD;
			end
			STEP_INIT: begin
				w.init_pass = 1'b1;
			end
			STEP_SWEEP: begin
				w.sweep = 1'b1;
				w.cond  = COND_SWEEP_BUSY;
				w.jump  = STEP_SWEEP;
			end
			STEP_NEXT: begin
				w.next_part = 1'b1;
				w.cond      = COND_MORE_PARTS;
				w.jump      = STEP_INIT;
			end
			STEP_RESULT: begin
				w.rd_result = 1'b1;
			end
			STEP_LOAD: begin
				w.load_out = 1'b1;
				w.cond     = COND_OUT_FULL;
				w.jump     = STEP_LOAD;
			end
			STEP_RETURN: begin
				w.cond = COND_ALWAYS;
				w.jump = STEP_IDLE;
			end
			default: begin
				w = CTRL_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: sv/bcc_if.sv
// ----------------------------------------------------------------------------
// Bounded composition counter channels
// Valid/ready channels for the target query and the resulting count.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcc_query_if import bcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] target_total;

	modport source (output valid, output target_total, input ready);
	modport sink (input valid, input target_total, output ready);
endinterface

interface bcc_result_if import bcc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] way_count;

	modport source (output valid, output way_count, input ready);
	modport sink (input valid, input way_count, output ready);
endinterface

`default_nettype wire

FILE: sv/bounded_composition_counter.sv
// A query is taken only in the idle step. Each query runs five passes over the table, one per
// part; when a limit is below -1 or the target exceeds MAX_TOTAL, the count is zero instead.
// One query at a time: the next is taken only after the count is loaded into the output
// register, which waits for the previous count to leave it.
// Reset clears the sequencer, the limits (to -1) and the output valid flag; the table memory
// is not cleared, as every query rebuilds it from a unit series.
// ----------------------------------------------------------------------------
// Bounded composition counter
// Microcoded sequencer driving a sliding-window update of a two-bank table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_composition_counter_defines.svh"

module bounded_composition_counter import bcc_pkg::*; #(
	parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [LIMIT_W-1:0]   cfg_wdata,
	bcc_query_if.sink                 query,
	bcc_result_if.source              result
);

	localparam int AW = $clog2(MAX_TOTAL + 1);
	localparam int KW = TARGET_W + 1;

	logic [LIMIT_W-1:0]  lim_reg_q [NUM_PARTS];
	step_t               pc_q;
	step_t               pc_next;
	ctrl_word_t          ctrl;
	logic                jump_take;
	logic [TARGET_W-1:0] total_q;
	logic [TARGET_W-1:0] lim_q;
	logic [TARGET_W-1:0] lim_clamped;
	logic [PART_W-1:0]   part_q;
	logic                bank_q;
	logic                zero_q;
	logic                empty;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       sub_idx;
	logic                issue;
	logic                sub_en;
	logic                valid_s1;
	logic                first_s1;
	logic                sub_s1;
	logic                va_s1;
	logic                vb_s1;
	logic [KW-1:0]       k_s1;
	logic [COUNT_W-1:0]  mem_q [2][MAX_TOTAL+1];
	logic [COUNT_W-1:0]  rda_q;
	logic [COUNT_W-1:0]  rdb_q;
	logic [COUNT_W-1:0]  add_val;
	logic [COUNT_W-1:0]  sub_val;
	logic [COUNT_W-1:0]  acc_q;
	logic [COUNT_W-1:0]  w_next;
	logic [AW-1:0]       rda_addr;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  count_q;
	logic                rd_en;

	assign ctrl = ucode(pc_q);

	always_comb begin
		empty = (int'(total_q) > MAX_TOTAL);
		for (int i = 0; i < NUM_PARTS; i++) begin
			if ($signed(lim_reg_q[i]) < $signed({LIMIT_W{1'b1}})) begin
				empty = 1'b1;
			end
		end
	end

	always_comb begin
		if (lim_reg_q[part_q] == {LIMIT_W{1'b1}}) begin
			lim_clamped = total_q;
		end else if ($signed(lim_reg_q[part_q]) > $signed({1'b0, total_q})) begin
			lim_clamped = total_q;
		end else begin
			lim_clamped = lim_reg_q[part_q][TARGET_W-1:0];
		end
	end

	assign issue   = ctrl.sweep && (k_q <= {1'b0, total_q});
	assign sub_en  = k_q > {1'b0, lim_q};
	assign sub_idx = k_q - {1'b0, lim_q} - KW'(1);

	always_comb begin
		case (ctrl.cond)
			COND_NEVER:      jump_take = 1'b0;
			COND_ALWAYS:     jump_take = 1'b1;
			COND_NO_INPUT:   jump_take = !query.valid;
			COND_ZERO:       jump_take = empty;
			COND_SWEEP_BUSY: jump_take = issue || valid_s1;
			COND_MORE_PARTS: jump_take = (part_q != PART_W'(NUM_PARTS - 1));
			COND_OUT_FULL:   jump_take = out_valid_q;
			default:         jump_take = 1'b0;
		endcase
		pc_next = jump_take ? ctrl.jump : pc_q + step_t'(1);
	end

	assign query.ready = ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			part_q      <= '0;
			bank_q      <= 1'b0;
			zero_q      <= 1'b0;
			k_q         <= '0;
			lim_q       <= '0;
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			sub_s1      <= 1'b0;
			va_s1       <= 1'b0;
			vb_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PARTS; i++) begin
				lim_reg_q[i] <= {LIMIT_W{1'b1}};
			end
		end else begin
			pc_q <= pc_next;
			if (cfg_we && (int'(cfg_idx) < NUM_PARTS)) begin
				lim_reg_q[cfg_idx] <= cfg_wdata;
			end
			if (ctrl.setup) begin
				part_q <= '0;
				bank_q <= 1'b0;
				zero_q <= empty;
			end
			if (ctrl.init_pass) begin
				k_q   <= '0;
				lim_q <= lim_clamped;
			end else if (issue) begin
				k_q <= k_q + KW'(1);
			end
			if (ctrl.next_part) begin
				part_q <= part_q + PART_W'(1);
				bank_q <= !bank_q;
			end
			valid_s1 <= issue;
			first_s1 <= (part_q == '0);
			sub_s1   <= sub_en;
			va_s1    <= (k_q == '0);
			vb_s1    <= (sub_idx == '0);
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end else if (ctrl.load_out && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query.valid && query.ready) begin
			total_q <= query.target_total;
		end
		k_s1 <= k_q;
		if (ctrl.init_pass) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= w_next;
		end
		if (ctrl.load_out && !out_valid_q) begin
			count_q <= zero_q ? '0 : rda_q;
		end
	end

	assign rd_en    = issue || ctrl.rd_result;
	assign rda_addr = ctrl.rd_result ? AW'(total_q) : AW'(k_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rda_q <= mem_q[bank_q][rda_addr];
			rdb_q <= mem_q[bank_q][AW'(sub_idx)];
		end
		if (valid_s1) begin
			mem_q[!bank_q][AW'(k_s1)] <= w_next;
		end
	end

	always_comb begin
		add_val = first_s1 ? COUNT_W'(va_s1) : rda_q;
		if (!sub_s1) begin
			sub_val = '0;
		end else begin
			sub_val = first_s1 ? COUNT_W'(vb_s1) : rdb_q;
		end
		w_next = acc_q + add_val - sub_val;
	end

	assign result.valid     = out_valid_q;
	assign result.way_count = count_q;

	`BCC_ASSERT_NEXT(a_accept_to_setup, query.valid && query.ready, pc_q == STEP_SETUP, "transfer did not start setup")
	`BCC_ASSERT_HOLDS(a_write_in_sweep, !valid_s1 || pc_q == STEP_SWEEP, "table write outside a pass")
	`BCC_ASSERT_HOLDS(a_write_in_range, !valid_s1 || k_s1 <= KW'(total_q), "table write beyond target")
	`BCC_ASSERT_NEXT(a_load_shows, pc_q == STEP_LOAD && !out_valid_q, result.valid, "result not presented")

endmodule

`default_nettype wire
